FILE: hdl/jmss_pkg.sv
package jmss_pkg;

    localparam int DATA_W = 8;
    localparam int REM_W  = 16;

    typedef enum logic [7:0] {
        ST_START   = 8'b0000_0001,
        ST_ENTROPY = 8'b0000_0010,
        ST_SEGMENT = 8'b0000_0100,
        ST_FF      = 8'b0000_1000,
        ST_FFMM    = 8'b0001_0000,
        ST_FFMMNN  = 8'b0010_0000,
        ST_TRAILER = 8'b0100_0000,
        ST_ERROR   = 8'b1000_0000
    } t_state;

    typedef logic [2:0] t_kind;
    localparam t_kind K_STANDALONE = 3'd0;
    localparam t_kind K_PAYLOAD    = 3'd1;
    localparam t_kind K_EMPTY      = 3'd2;
    localparam t_kind K_ENDOK      = 3'd3;
    localparam t_kind K_ERROR      = 3'd4;

    typedef logic [1:0] t_err;
    localparam t_err E_NONE       = 2'd0;
    localparam t_err E_FALSESTART = 2'd1;
    localparam t_err E_ILLEGALLEN = 2'd2;
    localparam t_err E_TRUNCATED  = 2'd3;

    localparam logic [DATA_W-1:0] B_FILL = 8'hff;
    localparam logic [DATA_W-1:0] B_ZERO = 8'h00;
    localparam logic [DATA_W-1:0] M_TEM  = 8'h01;
    localparam logic [DATA_W-1:0] M_RST0 = 8'hd0;
    localparam logic [DATA_W-1:0] M_EOI  = 8'hd9;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    typedef struct packed {
        logic              valid;
        t_kind             kind;
        logic [DATA_W-1:0] marker;
        logic [DATA_W-1:0] payload;
        logic              last;
        t_err              err;
    } t_result;

    function automatic logic is_standalone(input logic [DATA_W-1:0] ch);
        return (ch == M_TEM) || (ch >= M_RST0 && ch <= M_EOI);
    endfunction

endpackage

FILE: hdl/jpeg_marker_segment_splitter_top.sv
// JPEG marker segment splitter.
// Input stream (s_axis): one word per stream byte. tdata carries the byte,
// tuser is the op flag: 0 = stream byte, 1 = end-of-stream check.
// Output stream (m_axis): zero or one word per input word. tuser is the
// result kind (standalone marker, payload byte, empty segment, end ok,
// error), tlast flags the final word of a segment, tdata carries the
// marker code, the payload byte and the error code.
// Words with no result (fill bytes, entropy-coded data, header bytes,
// any stream byte after EOI or after an error) are dropped silently.
// Path: an accepted word is registered in the input register, parsed from
// there, and its result is registered in the result register that drives m_axis.
// Throughput: one word per cycle while m_axis does not stall; the parse
// state update is combinational logic between the input and result registers.
// Reset (synchronous, active low) returns the parser to its start state
// and empties both registers. When m_axis stalls, the result holds, the
// input register fills, and s_axis tready drops until the result is taken.
module jpeg_marker_segment_splitter_top
    import jmss_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tuser,   // [0] op
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [7:0] marker_code, [15:8] payload,
                                          // [17:16] error_code, [23:18] zero
    output logic [2:0]  o_m_axis_tuser,   // [2:0] kind
    output logic        o_m_axis_tlast    // last
);

    logic              r_in_valid;
    logic              r_in_op;
    logic [DATA_W-1:0] r_in_byte;
    logic              r_out_valid;
    t_result           r_out;
    t_result           step_res;
    logic              adv;

    // the parse stage moves whenever the result register is free or emptying
    assign adv             = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || adv;

    jmss_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_in_valid),
        .i_op    (r_in_op),
        .i_byte  (r_in_byte),
        .o_res   (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready) begin
            r_in_op   <= i_s_axis_tuser;
            r_in_byte <= i_s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= step_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= step_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.kind;
    assign o_m_axis_tlast  = r_out.last;
    assign o_m_axis_tdata  = {6'b0, r_out.err, r_out.payload, r_out.marker};

`ifndef SYNTHESIS
    a_ready_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_out_valid && !i_m_axis_tready))
        else $error("input stalled without an output stall");

    a_error_has_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == K_ERROR) |-> (o_m_axis_tdata[17:16] != E_NONE))
        else $error("error word without error code");

    a_code_only_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser != K_ERROR) |-> (o_m_axis_tdata[17:16] == E_NONE))
        else $error("error code on a non-error word");

    a_single_word_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == K_STANDALONE || o_m_axis_tuser == K_EMPTY))
        |-> o_m_axis_tlast)
        else $error("single-word segment without last");
`endif

endmodule

FILE: hdl/jmss_parse.sv
module jmss_parse
    import jmss_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic              i_op,
    input  logic [DATA_W-1:0] i_byte,
    output t_result           o_res
);

    t_state            r_state,  n_state;
    logic [DATA_W-1:0] r_marker, n_marker;
    logic [REM_W-1:0]  r_rem,    n_rem;
    logic              r_seen,   n_seen;

    logic [REM_W-1:0] rem_dec;
    logic [REM_W-1:0] seg_len;
    logic [REM_W-1:0] len_m2;

    assign rem_dec = r_rem - REM_W'(1);
    assign seg_len = {r_rem[REM_W-1:DATA_W], i_byte};
    assign len_m2  = seg_len - REM_W'(2);

    always_comb begin
        n_state  = r_state;
        n_marker = r_marker;
        n_rem    = r_rem;
        n_seen   = r_seen;
        o_res    = '0;

        if (i_valid) begin
            if (i_op == OP_END) begin
                o_res.valid = 1'b1;
                if (r_state == ST_ENTROPY || r_state == ST_TRAILER) begin
                    o_res.kind = K_ENDOK;
                end else if (r_state == ST_ERROR) begin
                    o_res.kind = K_ERROR;
                    o_res.err  = r_rem[1:0];
                end else begin
                    o_res.kind = K_ERROR;
                    o_res.err  = E_TRUNCATED;
                    n_state    = ST_ERROR;
                    n_rem      = REM_W'(E_TRUNCATED);
                end
            end else begin
                case (r_state)
                    ST_START: begin
                        if (i_byte == B_FILL) begin
                            n_state = ST_FF;
                        end else begin
                            o_res.valid = 1'b1;
                            o_res.kind  = K_ERROR;
                            o_res.err   = E_FALSESTART;
                            n_state     = ST_ERROR;
                            n_rem       = REM_W'(E_FALSESTART);
                        end
                    end
                    ST_ENTROPY: begin
                        if (i_byte == B_FILL) n_state = ST_FF;
                    end
                    ST_SEGMENT: begin
                        n_rem         = rem_dec;
                        o_res.valid   = 1'b1;
                        o_res.kind    = K_PAYLOAD;
                        o_res.marker  = r_marker;
                        o_res.payload = i_byte;
                        if (rem_dec == '0) begin
                            o_res.last = 1'b1;
                            n_state    = ST_ENTROPY;
                            n_seen     = 1'b1;
                        end
                    end
                    ST_FF: begin
                        if (i_byte == B_ZERO) begin
                            // stuffed zero is only legal once a segment was seen
                            if (!r_seen) begin
                                o_res.valid = 1'b1;
                                o_res.kind  = K_ERROR;
                                o_res.err   = E_FALSESTART;
                                n_state     = ST_ERROR;
                                n_rem       = REM_W'(E_FALSESTART);
                            end else begin
                                n_state = ST_ENTROPY;
                            end
                        end else if (i_byte == B_FILL) begin
                            n_state = ST_FF;
                        end else if (is_standalone(i_byte)) begin
                            o_res.valid  = 1'b1;
                            o_res.kind   = K_STANDALONE;
                            o_res.marker = i_byte;
                            o_res.last   = 1'b1;
                            n_seen       = 1'b1;
                            n_state      = (i_byte == M_EOI) ? ST_TRAILER : ST_ENTROPY;
                        end else begin
                            n_marker = i_byte;
                            n_rem    = '0;
                            n_state  = ST_FFMM;
                        end
                    end
                    ST_FFMM: begin
                        n_rem   = {i_byte, {DATA_W{1'b0}}};
                        n_state = ST_FFMMNN;
                    end
                    ST_FFMMNN: begin
                        if (seg_len < REM_W'(2)) begin
                            o_res.valid = 1'b1;
                            o_res.kind  = K_ERROR;
                            o_res.err   = E_ILLEGALLEN;
                            n_state     = ST_ERROR;
                            n_rem       = REM_W'(E_ILLEGALLEN);
                        end else if (len_m2 == '0) begin
                            n_rem        = len_m2;
                            o_res.valid  = 1'b1;
                            o_res.kind   = K_EMPTY;
                            o_res.marker = r_marker;
                            o_res.last   = 1'b1;
                            n_seen       = 1'b1;
                            n_state      = ST_ENTROPY;
                        end else begin
                            n_rem   = len_m2;
                            n_state = ST_SEGMENT;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_START;
            r_marker <= '0;
            r_rem    <= '0;
            r_seen   <= 1'b0;
        end else if (i_en) begin
            r_state  <= n_state;
            r_marker <= n_marker;
            r_rem    <= n_rem;
            r_seen   <= n_seen;
        end
    end

endmodule
